// ===== sv/tphc_pkg.sv =====
// Shared types and constants for the transport pseudo-header checksum core.
`default_nettype none
package tphc_pkg;

   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SOURCE_ADDRESS      = 2'd0,
      CSR_DESTINATION_ADDRESS = 2'd1,
      CSR_PROTOCOL_NUMBER     = 2'd2
   } csr_index_type;

   localparam logic [7:0]  UDP_PROTOCOL        = 8'd17;
   localparam logic [7:0]  TCP_PROTOCOL        = 8'd6;
   localparam logic [14:0] UDP_CHECKSUM_WORD   = 15'd3;
   localparam logic [14:0] TCP_CHECKSUM_WORD   = 15'd8;
   localparam logic [15:0] WORD_MASK           = 16'hffff;
   localparam logic [7:0]  PROTOCOL_RESET      = UDP_PROTOCOL;

   // segment totals handed from the accumulator to the pseudo-header stage
   typedef struct packed {
      logic [15:0] running_sum;
      logic [15:0] byte_count;
      logic        count_saturated;
   } segment_totals_type;

   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [7:0]  protocol_number;
   } pseudo_header_type;

endpackage
`default_nettype wire

// ===== sv/tphc_req_if.sv =====
// Segment word channel interface.
`default_nettype none
interface tphc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] segment_word;
   logic        odd_byte;
   logic        last_word;

   modport source (output valid, output segment_word, output odd_byte, output last_word,
                   input ready);
   modport sink   (input valid, input segment_word, input odd_byte, input last_word,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/tphc_rsp_if.sv =====
// Checksum result channel interface.
`default_nettype none
interface tphc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] checksum_value;
   logic        length_overflow;

   modport source (output valid, output checksum_value, output length_overflow,
                   input ready);
   modport sink   (input valid, input checksum_value, input length_overflow,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/tphc_csr_if.sv =====
// Register write channel interface.
`default_nettype none
interface tphc_csr_if import tphc_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [31:0]                data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/tphc_csr_regs.sv =====
// Configuration registers: addresses and protocol number.
`default_nettype none
module tphc_csr_regs import tphc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   tphc_csr_if.sink         csr_chan,
   output pseudo_header_type header
);

   logic [31:0] source_ff;
   logic [31:0] dest_ff;
   logic [7:0]  proto_ff;
   logic [31:0] source_in;
   logic [31:0] dest_in;
   logic [7:0]  proto_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      source_in = source_ff;
      dest_in   = dest_ff;
      proto_in  = proto_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SOURCE_ADDRESS:      source_in = csr_chan.data;
            CSR_DESTINATION_ADDRESS: dest_in   = csr_chan.data;
            CSR_PROTOCOL_NUMBER:     proto_in  = csr_chan.data[7:0];
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= '0;
         dest_ff   <= '0;
         proto_ff  <= PROTOCOL_RESET;
      end else begin
         source_ff <= source_in;
         dest_ff   <= dest_in;
         proto_ff  <= proto_in;
      end
   end

   assign header.source_address      = source_ff;
   assign header.destination_address = dest_ff;
   assign header.protocol_number     = proto_ff;

endmodule
`default_nettype wire

// ===== sv/tphc_accum.sv =====
// Running one's-complement sum and byte count over a segment.
`default_nettype none
module tphc_accum import tphc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   tphc_req_if.sink          req_chan,
   input  wire logic [7:0]   protocol_number,
   input  wire logic         totals_ready,
   output logic              totals_valid,
   output segment_totals_type totals
);

   logic [15:0]        sum_ff, sum_in;
   logic [15:0]        count_ff, count_in;
   logic               sat_ff, sat_in;
   logic               hold_ff, hold_in;
   segment_totals_type totals_ff, totals_in;

   logic        accept;
   logic        is_check;
   logic [15:0] word;
   logic [16:0] sum_wide;
   logic [15:0] sum_next;
   logic [16:0] count_wide;
   logic [15:0] count_next;
   logic        sat_next;

   assign req_chan.ready = !hold_ff || totals_ready;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      is_check = 1'b0;
      if (!sat_ff) begin
         if (protocol_number == UDP_PROTOCOL && count_ff[15:1] == UDP_CHECKSUM_WORD)
            is_check = 1'b1;
         if (protocol_number == TCP_PROTOCOL && count_ff[15:1] == TCP_CHECKSUM_WORD)
            is_check = 1'b1;
      end
      word = req_chan.odd_byte ? {req_chan.segment_word[15:8], 8'h00}
                               : req_chan.segment_word;
      if (is_check)
         word = '0;
      // end-around carry
      sum_wide   = {1'b0, sum_ff} + {1'b0, word};
      sum_next   = sum_wide[15:0] + {15'd0, sum_wide[16]};
      count_wide = {1'b0, count_ff} + (req_chan.odd_byte ? 17'd1 : 17'd2);
      count_next = count_wide[16] ? WORD_MASK : count_wide[15:0];
      sat_next   = sat_ff || count_wide[16];
   end

   always_comb begin
      sum_in    = sum_ff;
      count_in  = count_ff;
      sat_in    = sat_ff;
      hold_in   = hold_ff && !totals_ready;
      totals_in = totals_ff;
      if (accept) begin
         if (req_chan.last_word) begin
            // hand off totals, clear for the next segment
            totals_in.running_sum     = sum_next;
            totals_in.byte_count      = count_next;
            totals_in.count_saturated = sat_next;
            hold_in  = 1'b1;
            sum_in   = '0;
            count_in = '0;
            sat_in   = 1'b0;
         end else begin
            sum_in   = sum_next;
            count_in = count_next;
            sat_in   = sat_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         sat_ff   <= 1'b0;
         hold_ff  <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         sat_ff   <= sat_in;
         hold_ff  <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      totals_ff <= totals_in;
   end

   assign totals_valid = hold_ff;
   assign totals       = totals_ff;

endmodule
`default_nettype wire

// ===== sv/tphc_fold.sv =====
// Pseudo-header addition, fold and inversion into the result register.
`default_nettype none
module tphc_fold import tphc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               totals_valid,
   input  wire segment_totals_type totals,
   input  wire pseudo_header_type  header,
   output logic                    totals_ready,
   tphc_rsp_if.source              rsp_chan
);

   logic        out_valid_ff, out_valid_in;
   logic [15:0] checksum_ff, checksum_in;
   logic        overflow_ff, overflow_in;

   logic [18:0] total;
   logic [16:0] fold_a;
   logic [15:0] fold_b;
   logic        take;

   assign totals_ready = !out_valid_ff || rsp_chan.ready;
   assign take = totals_valid && totals_ready;

   // seven 16-bit terms fit in 19 bits; two folds bring it back to 16
   always_comb begin
      total = {3'd0, totals.running_sum}
            + {3'd0, header.source_address[31:16]}
            + {3'd0, header.source_address[15:0]}
            + {3'd0, header.destination_address[31:16]}
            + {3'd0, header.destination_address[15:0]}
            + {11'd0, header.protocol_number}
            + {3'd0, totals.byte_count};
      fold_a = {1'b0, total[15:0]} + {14'd0, total[18:16]};
      fold_b = fold_a[15:0] + {15'd0, fold_a[16]};
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      checksum_in  = checksum_ff;
      overflow_in  = overflow_ff;
      if (take) begin
         out_valid_in = 1'b1;
         checksum_in  = ~fold_b;
         overflow_in  = totals.count_saturated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else
         out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      checksum_ff <= checksum_in;
      overflow_ff <= overflow_in;
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.checksum_value  = checksum_ff;
   assign rsp_chan.length_overflow = overflow_ff;

endmodule
`default_nettype wire

// ===== sv/transport_pseudo_header_checksum_core.sv =====
// UDP/TCP checksum with IPv4 pseudo-header: top level.
//
// req_chan carries a segment as big-endian 16-bit words with odd_byte for a
// final padded byte and last_word on the segment's final word. One word is
// taken every cycle while the totals register is empty or being handed on;
// the running sum uses a single 16-bit add with end-around carry, so the
// sustained rate is one word per clock. rsp_chan carries one result per
// segment: the inverted checksum and a length overflow flag. A segment's
// totals go to the totals register, then to the result register that
// holds the pseudo-header add and fold.
// csr_chan writes the source address, destination address and protocol
// number; it is always ready. Protocol 17 zeroes word 3 and protocol 6
// zeroes word 8 of the segment.
// Reset clears the segment state, the addresses and sets the protocol to 17.
// When rsp_chan stalls the result holds and one more finished segment waits
// in the totals register; req_chan then stalls on every word until the
// result register can take those totals.
`default_nettype none
module transport_pseudo_header_checksum_core import tphc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   tphc_req_if.sink   req_chan,
   tphc_rsp_if.source rsp_chan,
   tphc_csr_if.sink   csr_chan
);

   pseudo_header_type  header;
   segment_totals_type totals;
   logic               totals_valid;
   logic               totals_ready;

   tphc_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .header   (header)
   );

   tphc_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .protocol_number (header.protocol_number),
      .totals_ready    (totals_ready),
      .totals_valid    (totals_valid),
      .totals          (totals)
   );

   tphc_fold u_fold (
      .clock        (clock),
      .reset        (reset),
      .totals_valid (totals_valid),
      .totals       (totals),
      .header       (header),
      .totals_ready (totals_ready),
      .rsp_chan     (rsp_chan)
   );

endmodule
`default_nettype wire

// ===== dv/tphc_tb_pkg.sv =====
`timescale 1ns / 100ps
// Checksum tracker class: predicts each segment's checksum and compares the results.
package tphc_tb_pkg;
   import tphc_pkg::*;

   typedef struct packed {
      logic [15:0] checksum_value;
      logic        length_overflow;
   } checksum_result_type;

   class checksum_tracker;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [7:0]  protocol_number;
      logic [15:0] segment_sum;
      logic [15:0] segment_bytes;
      logic        segment_saturated;
      checksum_result_type expected_checksums[$];
      int unsigned mismatches;
      int unsigned words_seen;
      int unsigned odd_words;
      int unsigned segments_seen;
      int unsigned overflow_segments;
      int unsigned udp_segments;
      int unsigned tcp_segments;
      int unsigned other_segments;
      int unsigned results_compared;

      function new();
         source_address      = '0;
         destination_address = '0;
         protocol_number     = PROTOCOL_RESET;
         clear_segment();
      endfunction

      function void clear_segment();
         segment_sum       = '0;
         segment_bytes     = '0;
         segment_saturated = 1'b0;
      endfunction

      // one's-complement add with end-around carry
      function logic [15:0] fold_add(logic [15:0] a, logic [15:0] b);
         logic [16:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[15:0] + {15'd0, s[16]};
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] index, logic [31:0] data);
         case (index)
            CSR_SOURCE_ADDRESS:      source_address = data;
            CSR_DESTINATION_ADDRESS: destination_address = data;
            CSR_PROTOCOL_NUMBER:     protocol_number = data[7:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_checksums.size();
      endfunction

      function void note_word(logic [15:0] word, logic odd, logic last);
         logic [15:0] term;
         logic [14:0] word_index;
         logic [16:0] next_count;
         logic        zero_word;
         logic [15:0] total;
         word_index = segment_bytes[15:1];
         zero_word  = !segment_saturated &&
                      ((protocol_number == UDP_PROTOCOL && word_index == UDP_CHECKSUM_WORD) ||
                       (protocol_number == TCP_PROTOCOL && word_index == TCP_CHECKSUM_WORD));
         term = odd ? {word[15:8], 8'h00} : word;
         if (zero_word) term = '0;
         segment_sum = fold_add(segment_sum, term);
         next_count = {1'b0, segment_bytes} + (odd ? 17'd1 : 17'd2);
         if (next_count > {1'b0, WORD_MASK}) begin
            segment_bytes     = WORD_MASK;
            segment_saturated = 1'b1;
         end else begin
            segment_bytes = next_count[15:0];
         end
         words_seen++;
         if (odd) odd_words++;
         if (!last) return;
         // fold in the pseudo-header as it stands on the last word
         total = fold_add(segment_sum, source_address[31:16]);
         total = fold_add(total, source_address[15:0]);
         total = fold_add(total, destination_address[31:16]);
         total = fold_add(total, destination_address[15:0]);
         total = fold_add(total, {8'h00, protocol_number});
         total = fold_add(total, segment_bytes);
         expected_checksums.push_back('{checksum_value: ~total,
                                        length_overflow: segment_saturated});
         segments_seen++;
         if (segment_saturated) overflow_segments++;
         if (protocol_number == UDP_PROTOCOL) udp_segments++;
         else if (protocol_number == TCP_PROTOCOL) tcp_segments++;
         else other_segments++;
         clear_segment();
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 20) $display("mismatch: %s", what);
      endtask

      task check_checksum(logic [15:0] value, logic overflow);
         checksum_result_type want;
         results_compared++;
         if (expected_checksums.size() == 0) begin
            report($sformatf("checksum %h with no segment outstanding", value));
            return;
         end
         want = expected_checksums.pop_front();
         if (value !== want.checksum_value)
            report($sformatf("checksum_value %h, expected %h", value, want.checksum_value));
         if (overflow !== want.length_overflow)
            report($sformatf("length_overflow %b, expected %b", overflow,
                             want.length_overflow));
      endtask

      task check_leftovers();
         if (expected_checksums.size() != 0)
            report($sformatf("%0d checksums never arrived", expected_checksums.size()));
      endtask
   endclass

endpackage

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench for the transport pseudo-header checksum core.
module tb;
   import tphc_pkg::*;
   import tphc_tb_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic gaps_on = 1'b0;
   logic hold_off_toggle = 1'b0;
   int unsigned cycle_count = 0;

   tphc_req_if req_chan();
   tphc_rsp_if rsp_chan();
   tphc_csr_if csr_chan();

   checksum_tracker tracker = new();

   transport_pseudo_header_checksum_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // result side: random back-pressure plus one long hold-off on request
   initial begin
      int unsigned stall_left;
      logic        hold_off_seen;
      stall_left = 0;
      hold_off_seen = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            tracker.check_checksum(rsp_chan.checksum_value, rsp_chan.length_overflow);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_off_toggle != hold_off_seen) begin
            hold_off_seen = hold_off_toggle;
            stall_left = 150;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !(gaps_on && $urandom_range(99) < 20);
         end
      end
   end

   function automatic logic [15:0] random_word();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return 16'h0000;
      if (pick < 20) return 16'hffff;
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] random_address();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 20) return 32'h0000_0000;
      if (pick < 40) return 32'hffff_ffff;
      return $urandom;
   endfunction

   task automatic send_word(input logic [15:0] word, input logic odd, input logic last);
      while (gaps_on && $urandom_range(99) < 20) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.segment_word <= word;
      req_chan.odd_byte     <= odd;
      req_chan.last_word    <= last;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_word(word, odd, last);
   endtask

   task automatic send_segment(input int unsigned words);
      logic last;
      logic odd;
      for (int unsigned i = 0; i < words; i++) begin
         last = (i == words - 1);
         odd  = last ? ($urandom_range(99) < 30) : ($urandom_range(99) < 5);
         send_word(random_word(), odd, last);
      end
   endtask

   // stop offering and wait until every checksum is back and the core is quiet
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_registers(input logic [31:0] source, input logic [31:0] destination,
                                    input logic [7:0] protocol, input logic add_unused);
      logic [CSR_INDEX_WIDTH-1:0] indexes[4];
      logic [31:0]                values[4];
      int unsigned                count;
      indexes[0] = CSR_SOURCE_ADDRESS;      values[0] = source;
      indexes[1] = CSR_DESTINATION_ADDRESS; values[1] = destination;
      count = 2;
      if (add_unused) begin
         indexes[count] = CSR_UNUSED_INDEX;
         values[count]  = $urandom;
         count++;
      end
      indexes[count] = CSR_PROTOCOL_NUMBER; values[count] = {24'($urandom), protocol};
      count++;
      for (int unsigned i = 0; i < count; i++) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= indexes[i];
         csr_chan.data  <= values[i];
         do @(posedge clock); while (!csr_chan.ready);
         tracker.set_register(indexes[i], values[i]);
      end
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      int unsigned phase_words;
      int unsigned length;
      logic [7:0]  protocol;
      req_chan.valid        = 1'b0;
      req_chan.segment_word = '0;
      req_chan.odd_byte     = 1'b0;
      req_chan.last_word    = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = CSR_SOURCE_ADDRESS;
      csr_chan.data         = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: UDP with zero addresses; word 3 must be summed as zero
      send_word(16'h0000, 1'b0, 1'b0);
      send_word(16'hffff, 1'b0, 1'b0);
      send_word(16'h8000, 1'b0, 1'b0);
      send_word(16'habcd, 1'b0, 1'b0);
      send_word(16'h0001, 1'b0, 1'b0);
      send_word(16'h7fff, 1'b0, 1'b1);
      send_word(16'hffff, 1'b0, 1'b1);
      send_word(16'hff5a, 1'b1, 1'b1);
      // odd byte mid-segment shifts the count so the fifth word lands on index 3
      send_word(16'h1234, 1'b0, 1'b0);
      send_word(16'h56ff, 1'b1, 1'b0);
      send_word(16'h9abc, 1'b0, 1'b0);
      send_word(16'hdef0, 1'b0, 1'b0);
      send_word(16'h1111, 1'b0, 1'b1);
      drain_results();

      // TCP with all-ones addresses: word 8 summed as zero, odd last byte
      program_registers(32'hffff_ffff, 32'hffff_ffff, TCP_PROTOCOL, 1'b1);
      for (int unsigned i = 0; i < 10; i++)
         send_word(i == 8 ? 16'hbeef : random_word(), i == 9, i == 9);
      drain_results();

      // protocol that zeroes no word
      program_registers(32'h0000_0000, 32'h0000_0000, 8'h00, 1'b0);
      send_word(16'hffff, 1'b0, 1'b0);
      send_word(16'hffff, 1'b0, 1'b1);
      drain_results();

      for (int unsigned phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       protocol = 8'hff;
            1:       protocol = UDP_PROTOCOL;
            2:       protocol = TCP_PROTOCOL;
            default: begin
               length = $urandom_range(99);
               if (length < 40)      protocol = UDP_PROTOCOL;
               else if (length < 70) protocol = TCP_PROTOCOL;
               else if (length < 80) protocol = 8'h00;
               else                  protocol = 8'($urandom);
            end
         endcase
         program_registers(random_address(), random_address(), protocol,
                           $urandom_range(99) < 30);
         gaps_on = (phase != 3);
         phase_words = 0;
         if (phase == 5) begin
            // fill the core with short segments while results are held off
            hold_off_toggle <= !hold_off_toggle;
            for (int unsigned i = 0; i < 40; i++) send_segment(1);
            phase_words = 40;
         end
         while (phase_words < 95) begin
            length = $urandom_range(99);
            if (length < 5)       length = 1;
            else if (length < 75) length = $urandom_range(12, 1);
            else                  length = $urandom_range(40, 13);
            send_segment(length);
            phase_words += length;
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      tracker.check_leftovers();
      $display("covered %0d words in %0d segments, %0d odd bytes, %0d length overflows",
               tracker.words_seen, tracker.segments_seen, tracker.odd_words,
               tracker.overflow_segments);
      $display("segments udp %0d tcp %0d other %0d; %0d results compared, %0d mismatches",
               tracker.udp_segments, tracker.tcp_segments, tracker.other_segments,
               tracker.results_compared, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
